// ===== design/json_string_unescape_utf8_macros.svh =====
// ----------------------------------------------------------------------------
// json string unescape assertion macros
// shared assertion forms, compiled out when ASSERT_OFF is set
// ----------------------------------------------------------------------------
`ifndef JSON_STRING_UNESCAPE_UTF8_MACROS_SVH
`define JSON_STRING_UNESCAPE_UTF8_MACROS_SVH

`ifndef ASSERT_OFF
`define JSU_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
`define JSU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define JSU_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define JSU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== design/jsu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_pkg
// shared types, status codes and utf-8 helpers for the string unescaper
// ----------------------------------------------------------------------------
package jsu_pkg;

  localparam int unsigned FifoDepthDefault = 4;

  localparam logic [3:0] ST_BYTE       = 4'd0;
  localparam logic [3:0] ST_END        = 4'd1;
  localparam logic [3:0] ST_UNTERM     = 4'd2;
  localparam logic [3:0] ST_BS_END     = 4'd3;
  localparam logic [3:0] ST_INV_ESC    = 4'd4;
  localparam logic [3:0] ST_CTRL       = 4'd5;
  localparam logic [3:0] ST_BAD_HEX    = 4'd6;
  localparam logic [3:0] ST_TRUNC      = 4'd7;
  localparam logic [3:0] ST_BAD_LOW    = 4'd8;
  localparam logic [3:0] ST_DANGLING   = 4'd9;
  localparam logic [3:0] ST_LONE_LOW   = 4'd10;
  localparam logic [3:0] ST_NO_QUOTE   = 4'd11;

  // one queued item: up to four utf-8 bytes, then an optional status result
  typedef struct packed {
    logic [20:0] cp;
    logic [2:0]  nbytes;
    logic [3:0]  tail;
  } job_t;

  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  function automatic logic [2:0] utf8_len(input logic [20:0] cp);
    logic [2:0] r;
    if (cp <= 21'h7F) begin
      r = 3'd1;
    end else if (cp <= 21'h7FF) begin
      r = 3'd2;
    end else if (cp <= 21'hFFFF) begin
      r = 3'd3;
    end else begin
      r = 3'd4;
    end
    return r;
  endfunction

  function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [2:0] n,
                                           input logic [1:0] idx);
    logic [7:0] r;
    r = 8'h00;
    unique case (n)
      3'd2: begin
        r = (idx == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
      end
      3'd3: begin
        unique case (idx)
          2'd0:    r = {4'b1110, cp[15:12]};
          2'd1:    r = {2'b10, cp[11:6]};
          default: r = {2'b10, cp[5:0]};
        endcase
      end
      3'd4: begin
        unique case (idx)
          2'd0: r = {5'b11110, cp[20:18]};
          2'd1: r = {2'b10, cp[17:12]};
          2'd2: r = {2'b10, cp[11:6]};
          2'd3: r = {2'b10, cp[5:0]};
        endcase
      end
      default: r = cp[7:0];
    endcase
    return r;
  endfunction

endpackage

// ===== design/jsu_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_front
// per-byte decode state machine; turns each item into at most one queued job
// ----------------------------------------------------------------------------
module jsu_front (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         accept_i,
  input  logic [7:0]   in_byte_i,
  input  logic         end_of_input_i,
  output logic         job_valid_o,
  output jsu_pkg::job_t job_o
);
  import jsu_pkg::*;

  localparam logic [2:0] M_IDLE       = 3'd0;
  localparam logic [2:0] M_STR        = 3'd1;
  localparam logic [2:0] M_ESC        = 3'd2;
  localparam logic [2:0] M_HEX1       = 3'd3;
  localparam logic [2:0] M_AFTER_HIGH = 3'd4;
  localparam logic [2:0] M_HIGH_BS    = 3'd5;
  localparam logic [2:0] M_HEX2       = 3'd6;

  logic [2:0]  mode_q, mode_d;
  logic [15:0] acc_q, acc_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [9:0]  pend_q, pend_d;

  logic [3:0]  err;
  logic [4:0]  hv;
  logic [15:0] v;
  logic [20:0] cp;
  logic [2:0]  nb;
  logic [3:0]  tail;

  always_comb begin
    mode_d = mode_q;
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    pend_d = pend_q;
    err    = ST_BYTE;
    cp     = 21'd0;
    nb     = 3'd0;
    tail   = ST_BYTE;
    hv     = hex_val(in_byte_i);
    v      = {acc_q[11:0], hv[3:0]};
    unique case (mode_q)
      M_STR: begin
        if (in_byte_i == 8'h22) begin
          tail   = ST_END;
          mode_d = M_IDLE;
        end else if (in_byte_i == 8'h5C) begin
          mode_d = M_ESC;
        end else if (in_byte_i < 8'h20) begin
          err = ST_CTRL;
        end else begin
          cp = {13'd0, in_byte_i};
          nb = 3'd1;
        end
      end
      M_ESC: begin
        mode_d = M_STR;
        nb     = 3'd1;
        unique case (in_byte_i)
          8'h22, 8'h5C, 8'h2F: cp = {13'd0, in_byte_i};
          8'h62: cp = 21'h08;
          8'h66: cp = 21'h0C;
          8'h6E: cp = 21'h0A;
          8'h72: cp = 21'h0D;
          8'h74: cp = 21'h09;
          8'h75: begin
            nb     = 3'd0;
            mode_d = M_HEX1;
            acc_d  = 16'd0;
            cnt_d  = 2'd0;
          end
          default: begin
            nb  = 3'd0;
            err = ST_INV_ESC;
          end
        endcase
      end
      M_HEX1, M_HEX2: begin
        if (!hv[4]) begin
          err = ST_BAD_HEX;
        end else if (cnt_q != 2'd3) begin
          acc_d = v;
          cnt_d = cnt_q + 2'd1;
        end else begin
          acc_d = 16'd0;
          cnt_d = 2'd0;
          if (mode_q == M_HEX1) begin
            if (v >= 16'hD800 && v <= 16'hDBFF) begin
              pend_d = v[9:0];
              mode_d = M_AFTER_HIGH;
            end else if (v >= 16'hDC00 && v <= 16'hDFFF) begin
              err = ST_LONE_LOW;
            end else begin
              cp     = {5'd0, v};
              nb     = utf8_len(cp);
              mode_d = M_STR;
            end
          end else begin
            if (v >= 16'hDC00 && v <= 16'hDFFF) begin
              cp     = 21'h10000 + {1'b0, pend_q, v[9:0]};
              nb     = 3'd4;
              pend_d = 10'd0;
              mode_d = M_STR;
            end else begin
              err = ST_BAD_LOW;
            end
          end
        end
      end
      M_AFTER_HIGH: begin
        if (in_byte_i == 8'h5C) begin
          mode_d = M_HIGH_BS;
        end else begin
          err = ST_DANGLING;
        end
      end
      M_HIGH_BS: begin
        if (in_byte_i == 8'h75) begin
          mode_d = M_HEX2;
          acc_d  = 16'd0;
          cnt_d  = 2'd0;
        end else begin
          err = ST_DANGLING;
        end
      end
      default: begin
        if (in_byte_i == 8'h22) begin
          mode_d = M_STR;
        end else begin
          err = ST_NO_QUOTE;
        end
      end
    endcase

    if (err == ST_BYTE && end_of_input_i) begin
      unique case (mode_d)
        M_STR:                  err = ST_UNTERM;
        M_ESC:                  err = ST_BS_END;
        M_HEX1, M_HEX2:         err = ST_TRUNC;
        M_AFTER_HIGH, M_HIGH_BS: err = ST_DANGLING;
        default:                err = ST_BYTE;
      endcase
    end

    if (err != ST_BYTE) begin
      tail   = err;
      mode_d = M_IDLE;
      acc_d  = 16'd0;
      cnt_d  = 2'd0;
      pend_d = 10'd0;
    end
  end

  assign job_o       = '{cp: cp, nbytes: nb, tail: tail};
  assign job_valid_o = accept_i && (nb != 3'd0 || tail != ST_BYTE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE;
      acc_q  <= 16'd0;
      cnt_q  <= 2'd0;
      pend_q <= 10'd0;
    end else if (accept_i) begin
      mode_q <= mode_d;
      acc_q  <= acc_d;
      cnt_q  <= cnt_d;
      pend_q <= pend_d;
    end
  end

endmodule

// ===== design/jsu_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_fifo
// short job queue between the decoder and the byte emitter
// ----------------------------------------------------------------------------
module jsu_fifo #(
  parameter int unsigned Depth = jsu_pkg::FifoDepthDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  jsu_pkg::job_t wdata_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output jsu_pkg::job_t rdata_o
);
  import jsu_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == LastPtr) ? '0 : wr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == LastPtr) ? '0 : rd_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

// ===== design/jsu_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_back
// walks each queued job and emits its results into an output register
// ----------------------------------------------------------------------------
module jsu_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_avail_i,
  input  jsu_pkg::job_t job_i,
  output logic          job_done_o,
  output logic          empty_o,
  input  logic          pop_i,
  output logic [7:0]    out_byte_o,
  output logic [3:0]    status_o,
  output logic          last_of_run_o
);
  import jsu_pkg::*;

  logic       out_vld_q;
  logic [7:0] byte_q;
  logic [3:0] status_q;
  logic       last_q;
  logic [2:0] idx_q;

  logic       load;
  logic [2:0] total;
  logic       is_last;
  logic       in_bytes;
  logic [7:0] byte_d;
  logic [3:0] status_d;

  always_comb begin
    total    = job_i.nbytes + ((job_i.tail != ST_BYTE) ? 3'd1 : 3'd0);
    is_last  = (idx_q == total - 3'd1);
    in_bytes = (idx_q < job_i.nbytes);
    byte_d   = in_bytes ? utf8_byte(job_i.cp, job_i.nbytes, idx_q[1:0]) : 8'h00;
    status_d = in_bytes ? ST_BYTE : job_i.tail;
  end

  assign load       = job_avail_i && (!out_vld_q || pop_i);
  assign job_done_o = load && is_last;

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q   <= byte_d;
      status_q <= status_d;
      last_q   <= is_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      idx_q     <= 3'd0;
    end else begin
      if (load) begin
        out_vld_q <= 1'b1;
        idx_q     <= is_last ? 3'd0 : idx_q + 3'd1;
      end else if (pop_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign empty_o       = !out_vld_q;
  assign out_byte_o    = byte_q;
  assign status_o      = status_q;
  assign last_of_run_o = last_q;

endmodule

// ===== design/json_string_unescape_utf8.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_unescape_utf8
// decodes a json string literal, one raw byte per item, into utf-8 bytes
// ----------------------------------------------------------------------------
// usage:
//   input channel: drive in_byte_i / end_of_input_i with push; an item is
//   taken on a clock edge with push high and full low.
//   result channel: while empty is low the oldest result sits on out_byte_o,
//   status_o and last_of_run_o; pop takes it.
//   each item gives zero to five results; last_of_run_o marks the final one.
// timing:
//   the decoder takes one item per cycle while full is low. the emitter
//   drains one result per cycle while pop is high, so an item with more
//   results holds the emitter longer; a job queue of FifoDepth entries
//   absorbs the difference. each job passes the queue, then the output register.
// stall:
//   when pop stays low the output register holds, the queue fills, and full
//   rises once FifoDepth jobs wait. items with no result never occupy it.
// reset:
//   rst_ni clears the decoder to idle (waiting for an opening quote), empties
//   the queue and drops any result in the output register.
// ----------------------------------------------------------------------------
`include "json_string_unescape_utf8_macros.svh"

module json_string_unescape_utf8 #(
  parameter int unsigned FifoDepth = jsu_pkg::FifoDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_input_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte_o,
  output logic [3:0] status_o,
  output logic       last_of_run_o
);
  import jsu_pkg::*;

  logic accept;
  logic job_push;
  job_t job_in;
  logic fifo_full;
  logic fifo_empty;
  job_t job_head;
  logic job_pop;

  assign full   = fifo_full;
  assign accept = push && !fifo_full;

  jsu_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .in_byte_i      (in_byte_i),
    .end_of_input_i (end_of_input_i),
    .job_valid_o    (job_push),
    .job_o          (job_in)
  );

  jsu_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .wdata_i (job_in),
    .full_o  (fifo_full),
    .pop_i   (job_pop),
    .empty_o (fifo_empty),
    .rdata_o (job_head)
  );

  jsu_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_avail_i   (!fifo_empty),
    .job_i         (job_head),
    .job_done_o    (job_pop),
    .empty_o       (empty),
    .pop_i         (pop),
    .out_byte_o    (out_byte_o),
    .status_o      (status_o),
    .last_of_run_o (last_of_run_o)
  );

  `JSU_ASSERT_IMPL(a_no_overflow, clk_i, rst_ni, job_push, !fifo_full)
  `JSU_ASSERT_IMPL(a_status_zero_byte, clk_i, rst_ni, !empty && status_o != ST_BYTE,
                   out_byte_o == 8'h00)
  `JSU_ASSERT_NEXT(a_job_end_last, clk_i, rst_ni, job_pop, !empty && last_of_run_o)

endmodule

// ===== tb/json_string_unescape_utf8_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_test
// Sends JSON string text one byte per item and checks every decoded result
// against a local decoder model. Covers plain bytes, the simple escapes,
// \u escapes at every UTF-8 length, surrogate pairs, each error status, and
// end of input in every decoder state. Both queue sides idle at random, and
// a long output stall fills the block.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_test;
  import jsu_pkg::*;

  localparam int ClkPeriod  = 10;
  localparam int CycleLimit = 200000;
  localparam int HoldCycles = 300;
  localparam int DrainWait  = 10;

  typedef enum logic [2:0] {
    MODE_IDLE, MODE_STR, MODE_ESC, MODE_HEX1, MODE_AFTER_HIGH, MODE_HIGH_BS, MODE_HEX2
  } decode_mode_e;

  typedef struct {
    logic [7:0] data;
    logic [3:0] status;
    logic       run_end;
  } decoded_t;

  logic       clk_i          = 1'b0;
  logic       rst_ni         = 1'b0;
  logic       push           = 1'b0;
  logic [7:0] in_byte_i      = 8'h00;
  logic       end_of_input_i = 1'b0;
  logic       pop            = 1'b0;
  logic       full;
  logic       empty;
  logic [7:0] out_byte_o;
  logic [3:0] status_o;
  logic       last_of_run_o;

  // decoder model state
  decode_mode_e dec_mode  = MODE_IDLE;
  logic [15:0]  hex_acc   = '0;
  logic [1:0]   hex_cnt   = '0;
  logic [9:0]   high_bits = '0;

  decoded_t   decoded_q[$];
  decoded_t   run_q[$];
  decoded_t   popped_r;
  logic [7:0] text_q[$];

  int send_idle_pct   = 0;
  int recv_idle_pct   = 0;
  bit hold_request    = 1'b0;
  int hold_left       = 0;
  int fail_count      = 0;
  int items_sent      = 0;
  int results_checked = 0;
  int input_stalls    = 0;
  int cycle_count     = 0;

  json_string_unescape_utf8 i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .in_byte_i     (in_byte_i),
    .end_of_input_i(end_of_input_i),
    .empty         (empty),
    .pop           (pop),
    .out_byte_o    (out_byte_o),
    .status_o      (status_o),
    .last_of_run_o (last_of_run_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // ---------------------------------------------------------------- model

  function automatic int digit_value(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - int'("0");
    if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
    if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
    return -1;
  endfunction

  function void emit(input logic [7:0] data, input logic [3:0] st);
    decoded_t r;
    r.data    = data;
    r.status  = st;
    r.run_end = 1'b0;
    run_q.insert(run_q.size(), r);
  endfunction

  function void encode_utf8(input logic [20:0] cp);
    if (cp <= 21'h7F) begin
      emit(cp[7:0], ST_BYTE);
    end else if (cp <= 21'h7FF) begin
      emit(8'hC0 | 8'(cp >> 6), ST_BYTE);
      emit(8'h80 | 8'(cp & 21'h3F), ST_BYTE);
    end else if (cp <= 21'hFFFF) begin
      emit(8'hE0 | 8'(cp >> 12), ST_BYTE);
      emit(8'h80 | 8'((cp >> 6) & 21'h3F), ST_BYTE);
      emit(8'h80 | 8'(cp & 21'h3F), ST_BYTE);
    end else begin
      emit(8'hF0 | 8'((cp >> 18) & 21'h07), ST_BYTE);
      emit(8'h80 | 8'((cp >> 12) & 21'h3F), ST_BYTE);
      emit(8'h80 | 8'((cp >> 6) & 21'h3F), ST_BYTE);
      emit(8'h80 | 8'(cp & 21'h3F), ST_BYTE);
    end
  endfunction

  function automatic void decode_byte(input logic [7:0] b, input logic eoi);
    logic [3:0]  err;
    int          d;
    logic [15:0] v;
    err = ST_BYTE;
    run_q.delete();
    case (dec_mode)
      MODE_STR: begin
        if (b == "\"") begin
          emit(8'h00, ST_END);
          dec_mode = MODE_IDLE;
        end else if (b == "\\") begin
          dec_mode = MODE_ESC;
        end else if (b < 8'h20) begin
          err = ST_CTRL;
        end else begin
          emit(b, ST_BYTE);
        end
      end
      MODE_ESC: begin
        dec_mode = MODE_STR;
        case (b)
          "\"", "\\", "/": emit(b, ST_BYTE);
          "b": emit(8'h08, ST_BYTE);
          "f": emit(8'h0C, ST_BYTE);
          "n": emit(8'h0A, ST_BYTE);
          "r": emit(8'h0D, ST_BYTE);
          "t": emit(8'h09, ST_BYTE);
          "u": begin
            dec_mode = MODE_HEX1;
            hex_acc  = '0;
            hex_cnt  = '0;
          end
          default: err = ST_INV_ESC;
        endcase
      end
      MODE_HEX1, MODE_HEX2: begin
        d = digit_value(b);
        if (d < 0) begin
          err = ST_BAD_HEX;
        end else begin
          hex_acc = {hex_acc[11:0], 4'(d)};
          if (hex_cnt < 2'd3) begin
            hex_cnt++;
          end else begin
            hex_cnt = '0;
            v       = hex_acc;
            hex_acc = '0;
            if (dec_mode == MODE_HEX1) begin
              if (v >= 16'hD800 && v <= 16'hDBFF) begin
                high_bits = v[9:0];
                dec_mode  = MODE_AFTER_HIGH;
              end else if (v >= 16'hDC00 && v <= 16'hDFFF) begin
                err = ST_LONE_LOW;
              end else begin
                encode_utf8({5'd0, v});
                dec_mode = MODE_STR;
              end
            end else if (v >= 16'hDC00 && v <= 16'hDFFF) begin
              encode_utf8(21'h10000 + {1'b0, high_bits, v[9:0]});
              high_bits = '0;
              dec_mode  = MODE_STR;
            end else begin
              err = ST_BAD_LOW;
            end
          end
        end
      end
      MODE_AFTER_HIGH: begin
        if (b == "\\") dec_mode = MODE_HIGH_BS;
        else err = ST_DANGLING;
      end
      MODE_HIGH_BS: begin
        if (b == "u") begin
          dec_mode = MODE_HEX2;
          hex_acc  = '0;
          hex_cnt  = '0;
        end else begin
          err = ST_DANGLING;
        end
      end
      default: begin
        if (b == "\"") dec_mode = MODE_STR;
        else err = ST_NO_QUOTE;
      end
    endcase

    if (err == ST_BYTE && eoi) begin
      case (dec_mode)
        MODE_STR:                      err = ST_UNTERM;
        MODE_ESC:                      err = ST_BS_END;
        MODE_HEX1, MODE_HEX2:          err = ST_TRUNC;
        MODE_AFTER_HIGH, MODE_HIGH_BS: err = ST_DANGLING;
        default: ;
      endcase
    end

    if (err != ST_BYTE) begin
      emit(8'h00, err);
      dec_mode  = MODE_IDLE;
      hex_acc   = '0;
      hex_cnt   = '0;
      high_bits = '0;
    end

    if (run_q.size() > 0) run_q[run_q.size() - 1].run_end = 1'b1;
    foreach (run_q[i]) decoded_q.insert(decoded_q.size(), run_q[i]);
  endfunction

  // -------------------------------------------------------------- sending

  task automatic send_item(input logic [7:0] b, input logic eoi);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push           <= 1'b1;
    in_byte_i      <= b;
    end_of_input_i <= eoi;
    @(posedge clk_i);
    while (full !== 1'b0) begin
      input_stalls++;
      @(posedge clk_i);
    end
    decode_byte(b, eoi);
    items_sent++;
  endtask

  task automatic send_str(input string s, input bit eoi_last);
    for (int i = 0; i < s.len(); i++) send_item(s[i], eoi_last && i == s.len() - 1);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) return 8'h30 + 8'(nib);
    return ($urandom_range(1) ? 8'h61 : 8'h41) + 8'(nib) - 8'd10;
  endfunction

  function void append_u_escape(input logic [15:0] v);
    text_q.insert(text_q.size(), "\\");
    text_q.insert(text_q.size(), "u");
    for (int i = 3; i >= 0; i--) text_q.insert(text_q.size(), hex_char(v[i*4 +: 4]));
  endfunction

  function void build_string();
    logic [7:0]  c;
    logic [15:0] v;
    logic [7:0]  esc_chars[8];
    logic [15:0] bmp_edges[6];
    int          nseg;
    esc_chars = '{"\"", "\\", "/", "b", "f", "n", "r", "t"};
    bmp_edges = '{16'h0000, 16'h007F, 16'h0080, 16'h07FF, 16'h0800, 16'hFFFF};
    text_q.delete();
    text_q.insert(text_q.size(), "\"");
    nseg = $urandom_range(0, 6);
    repeat (nseg) begin
      case ($urandom_range(5))
        0, 1: begin
          do c = 8'($urandom_range(8'h20, 8'hFF)); while (c == "\"" || c == "\\");
          text_q.insert(text_q.size(), c);
        end
        2: begin
          text_q.insert(text_q.size(), "\\");
          text_q.insert(text_q.size(), esc_chars[$urandom_range(7)]);
        end
        3: begin
          case ($urandom_range(3))
            0: v = 16'($urandom_range(16'h007F));
            1: v = 16'($urandom_range(16'h0080, 16'h07FF));
            2: do v = 16'($urandom_range(16'h0800, 16'hFFFF)); while (v[15:11] == 5'b11011);
            default: v = bmp_edges[$urandom_range(5)];
          endcase
          append_u_escape(v);
        end
        default: begin
          append_u_escape(16'hD800 + 16'($urandom_range(10'h3FF)));
          append_u_escape(16'hDC00 + 16'($urandom_range(10'h3FF)));
        end
      endcase
    end
    text_q.insert(text_q.size(), "\"");
  endfunction

  // mostly well-formed strings, some noise, corruption and early end of input
  task automatic send_random_string();
    int r;
    int eoi_at;
    int stop_at;
    build_string();
    eoi_at = -1;
    r = $urandom_range(99);
    if (r < 10) begin
      repeat ($urandom_range(1, 3)) send_item(8'($urandom_range(255)), 1'($urandom_range(1)));
    end else if (r < 25) begin
      text_q[$urandom_range(1, text_q.size() - 1)] = 8'($urandom_range(255));
    end else if (r < 35) begin
      eoi_at = $urandom_range(0, text_q.size() - 1);
    end else if (r < 40) begin
      eoi_at = text_q.size() - 1;
    end
    stop_at = (eoi_at >= 0) ? eoi_at : text_q.size() - 1;
    for (int i = 0; i <= stop_at; i++) send_item(text_q[i], i == eoi_at);
  endtask

  // ------------------------------------------------------------ checking

  always @(posedge clk_i) begin
    if (rst_ni && pop && empty === 1'b0) begin
      if (decoded_q.size() == 0) begin
        $error("unexpected result: out_byte %0h status %0d", out_byte_o, status_o);
        fail_count++;
      end else begin
        popped_r = decoded_q.pop_front();
        results_checked++;
        if (out_byte_o !== popped_r.data) begin
          $error("out_byte: expected %0h, got %0h", popped_r.data, out_byte_o);
          fail_count++;
        end
        if (status_o !== popped_r.status) begin
          $error("status: expected %0d, got %0d", popped_r.status, status_o);
          fail_count++;
        end
        if (last_of_run_o !== popped_r.run_end) begin
          $error("last_of_run: expected %0b, got %0b", popped_r.run_end, last_of_run_o);
          fail_count++;
        end
      end
    end
    if (hold_request) begin
      hold_left    = HoldCycles;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic test_no_quote();
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
  endtask

  task automatic test_string_body();
    send_str("\"", 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h1F, 1'b0);
    send_str("\"\\q", 1'b0);
    send_str("\"a", 1'b1);
    send_str("\"\\", 1'b1);
  endtask

  task automatic test_hex_escapes();
    send_str("\"\\u0000\"", 1'b0);
    send_str("\"\\u0G", 1'b0);
    send_str("\"\\u00", 1'b1);
    send_str("\"\\uDBFF", 1'b1);
    send_str("\"\\uDC00", 1'b0);
    send_str("\"\\uD800\\u0041", 1'b0);
    send_str("\"\\uD800x", 1'b0);
    send_str("\"\\uD800\\x", 1'b0);
  endtask

  task automatic test_backpressure();
    hold_request = 1'b1;
    send_str("\"", 1'b0);
    repeat (24) send_item(8'($urandom_range(8'h5D, 8'hFF)), 1'b0);
    send_str("\\uFFFF\\uD83D\\uDE00\"", 1'b0);
  endtask

  task automatic test_random_strings(input int count);
    int target;
    target = items_sent + count;
    while (items_sent < target) send_random_string();
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 29;
    recv_idle_pct = 71;
    test_no_quote();
    test_string_body();
    test_hex_escapes();
    test_random_strings(95);

    send_idle_pct = 71;
    recv_idle_pct = 29;
    test_random_strings(95);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_backpressure();
    test_random_strings(95);

    push <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    $display("sent %0d bytes of string text, checked %0d decoded results", items_sent,
             results_checked);
    $display("input held off by a full queue for %0d cycles", input_stalls);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/jsu_pkg.sv
design/jsu_front.sv
design/jsu_fifo.sv
design/jsu_back.sv
design/json_string_unescape_utf8.sv
tb/json_string_unescape_utf8_test.sv
